[hw/rtl/lrs_pkg.sv]
// Shared types, widths and constants for the log return stream core.
// Used by lrs_ctrl, lrs_datapath and log_return_stream_core; no dependencies.
package lrs_pkg;

  localparam int PRICE_W  = 32;
  localparam int FRAC_W   = 24;
  localparam int INT_W    = 8;
  localparam int RATIO_W  = INT_W + FRAC_W;
  localparam int XW       = RATIO_W + 1;
  localparam int PROD_W   = 2 * RATIO_W;
  localparam int SQ_W     = PROD_W - FRAC_W;
  localparam int SPLIT_W  = SQ_W / 2;
  localparam int LO_W     = SPLIT_W + RATIO_W;
  localparam int WIDE_W   = LO_W + SPLIT_W;
  localparam int M3_W     = SQ_W + RATIO_W - FRAC_W;
  localparam int SUM_W    = M3_W + 2;
  localparam int OUT_W    = 32;
  localparam int DIGIT_W  = 4;
  localparam int D3_STEPS = M3_W / DIGIT_W;
  localparam int CNT_W    = $clog2(RATIO_W);

  // floor(v/3) for v < 48 as (v * 43) >> 7
  localparam int DIV3_MUL = 43;
  localparam int DIV3_SH  = 7;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(RATIO_W - 1);
  localparam logic [CNT_W-1:0] D3_LAST  = CNT_W'(D3_STEPS - 1);

  localparam logic [XW-1:0] RATIO_ONE = XW'(1 << FRAC_W);

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sd2147483648);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_X,
    S_SQ,
    S_MLO,
    S_MHI,
    S_ACC,
    S_DIV3,
    S_SUM,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic clamp;
    logic zero_res;
    logic div_step;
    logic form_x;
    logic mul_sq;
    logic mul_lo;
    logic mul_hi;
    logic acc;
    logic d3_step;
    logic sum;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic prev_zero;
    logic too_big;
  } dp_stat_t;

endpackage

[hw/rtl/lrs_datapath.sv]
// Datapath: stored price, radix-2 ratio divider, shared multiplier,
// divide-by-3 digit unit and final sum with clamp. Depends on lrs_pkg.
module lrs_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  lrs_pkg::dp_cmd_t             cmd,
  output lrs_pkg::dp_stat_t            stat,
  input  logic [lrs_pkg::PRICE_W-1:0]  price,
  input  logic                         new_series,
  output logic [lrs_pkg::OUT_W-1:0]    res,
  output logic [1:0]                   res_status
);

  logic [lrs_pkg::PRICE_W-1:0] previous_price;
  logic                        have_previous;
  logic [lrs_pkg::PRICE_W-1:0] cur;
  logic [lrs_pkg::PRICE_W-1:0] prev;
  logic                        skip;
  logic [lrs_pkg::PRICE_W-1:0] rem;
  logic [lrs_pkg::RATIO_W-1:0] dsr;
  logic [lrs_pkg::RATIO_W-1:0] quot;
  logic                        sat;
  logic [lrs_pkg::XW-1:0]      x;
  logic [lrs_pkg::RATIO_W-1:0] ax;
  logic                        xneg;
  logic [lrs_pkg::PROD_W-1:0]  prod;
  logic [lrs_pkg::SQ_W-1:0]    s2;
  logic [lrs_pkg::LO_W-1:0]    plo;
  logic [lrs_pkg::M3_W-1:0]    m3;
  logic [lrs_pkg::M3_W-1:0]    t3;
  logic [1:0]                  d3r;

  logic [lrs_pkg::PRICE_W:0]     div_r2;
  logic                          div_ge;
  logic [lrs_pkg::PRICE_W:0]     div_diff;
  logic [lrs_pkg::XW-1:0]        x_c;
  logic [lrs_pkg::RATIO_W-1:0]   ax_c;
  logic [lrs_pkg::RATIO_W-1:0]   mul_a;
  logic [lrs_pkg::PROD_W-1:0]    mul_p;
  logic [lrs_pkg::WIDE_W-1:0]    wide;
  logic [5:0]                    d3_v;
  logic [11:0]                   d3_prod;
  logic [lrs_pkg::DIGIT_W-1:0]   d3_q;
  logic [5:0]                    d3_rem;
  logic signed [lrs_pkg::SUM_W-1:0] x_ext;
  logic signed [lrs_pkg::SUM_W-1:0] s2_half;
  logic signed [lrs_pkg::SUM_W-1:0] t3_ext;
  logic signed [lrs_pkg::SUM_W-1:0] sum_c;

  assign stat.skip      = skip;
  assign stat.prev_zero = (prev == '0);
  assign stat.too_big   = {{lrs_pkg::INT_W{1'b0}}, cur} >= {prev, {lrs_pkg::INT_W{1'b0}}};

  assign div_r2   = {rem, dsr[lrs_pkg::RATIO_W-1]};
  assign div_ge   = div_r2 >= {1'b0, prev};
  assign div_diff = div_r2 - {1'b0, prev};

  assign x_c  = {1'b0, quot} - lrs_pkg::RATIO_ONE;
  assign ax_c = x_c[lrs_pkg::XW-1] ? (~x_c[lrs_pkg::RATIO_W-1:0] + 1'b1)
                                   : x_c[lrs_pkg::RATIO_W-1:0];

  always_comb begin
    priority if (cmd.mul_lo) begin
      mul_a = {{(lrs_pkg::RATIO_W-lrs_pkg::SPLIT_W){1'b0}},
               prod[lrs_pkg::FRAC_W +: lrs_pkg::SPLIT_W]};
    end else if (cmd.mul_hi) begin
      mul_a = {{(lrs_pkg::RATIO_W-lrs_pkg::SPLIT_W){1'b0}},
               s2[lrs_pkg::SQ_W-1:lrs_pkg::SPLIT_W]};
    end else begin
      mul_a = ax;
    end
  end

  assign mul_p = lrs_pkg::PROD_W'(mul_a) * lrs_pkg::PROD_W'(ax);

  assign wide = {prod[lrs_pkg::LO_W-1:0], {lrs_pkg::SPLIT_W{1'b0}}}
              + {{lrs_pkg::SPLIT_W{1'b0}}, plo};

  // one base-16 digit of m3/3 per step
  assign d3_v    = {d3r, m3[lrs_pkg::M3_W-1 -: lrs_pkg::DIGIT_W]};
  assign d3_prod = {6'd0, d3_v} * 12'(lrs_pkg::DIV3_MUL);
  assign d3_q    = d3_prod[lrs_pkg::DIV3_SH +: lrs_pkg::DIGIT_W];
  assign d3_rem  = d3_v - {1'b0, d3_q, 1'b0} - {2'b00, d3_q};

  assign x_ext   = {{(lrs_pkg::SUM_W-lrs_pkg::XW){x[lrs_pkg::XW-1]}}, x};
  assign s2_half = {{(lrs_pkg::SUM_W-lrs_pkg::SQ_W+1){1'b0}}, s2[lrs_pkg::SQ_W-1:1]};
  assign t3_ext  = {{(lrs_pkg::SUM_W-lrs_pkg::M3_W){1'b0}}, t3};
  assign sum_c   = xneg ? (x_ext - s2_half - t3_ext) : (x_ext - s2_half + t3_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_price <= '0;
      have_previous  <= 1'b0;
    end else if (cmd.load) begin
      previous_price <= price;
      have_previous  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur  <= price;
      prev <= previous_price;
      skip <= new_series | ~have_previous;
      rem  <= {{lrs_pkg::INT_W{1'b0}}, price[lrs_pkg::PRICE_W-1:lrs_pkg::INT_W]};
      dsr  <= {price[lrs_pkg::INT_W-1:0], {lrs_pkg::FRAC_W{1'b0}}};
      quot <= '0;
      sat  <= 1'b0;
    end
    if (cmd.clamp) begin
      quot <= '1;
      sat  <= 1'b1;
    end
    if (cmd.div_step) begin
      dsr  <= {dsr[lrs_pkg::RATIO_W-2:0], 1'b0};
      quot <= {quot[lrs_pkg::RATIO_W-2:0], div_ge};
      rem  <= div_ge ? div_diff[lrs_pkg::PRICE_W-1:0] : div_r2[lrs_pkg::PRICE_W-1:0];
    end
    if (cmd.form_x) begin
      x    <= x_c;
      ax   <= ax_c;
      xneg <= x_c[lrs_pkg::XW-1];
    end
    if (cmd.mul_sq || cmd.mul_lo || cmd.mul_hi) begin
      prod <= mul_p;
    end
    if (cmd.mul_lo) begin
      s2 <= prod[lrs_pkg::FRAC_W +: lrs_pkg::SQ_W];
    end
    if (cmd.mul_hi) begin
      plo <= prod[lrs_pkg::LO_W-1:0];
    end
    if (cmd.acc) begin
      m3  <= wide[lrs_pkg::FRAC_W +: lrs_pkg::M3_W];
      t3  <= '0;
      d3r <= 2'b00;
    end
    if (cmd.d3_step) begin
      m3  <= {m3[lrs_pkg::M3_W-lrs_pkg::DIGIT_W-1:0], {lrs_pkg::DIGIT_W{1'b0}}};
      t3  <= {t3[lrs_pkg::M3_W-lrs_pkg::DIGIT_W-1:0], d3_q};
      d3r <= d3_rem[1:0];
    end
    if (cmd.zero_res) begin
      res        <= '0;
      res_status <= lrs_pkg::ST_DIV0;
    end
    if (cmd.sum) begin
      if (sum_c > lrs_pkg::SUM_MAX) begin
        res        <= lrs_pkg::SUM_MAX[lrs_pkg::OUT_W-1:0];
        res_status <= lrs_pkg::ST_SAT;
      end else if (sum_c < lrs_pkg::SUM_MIN) begin
        res        <= lrs_pkg::SUM_MIN[lrs_pkg::OUT_W-1:0];
        res_status <= lrs_pkg::ST_SAT;
      end else begin
        res        <= sum_c[lrs_pkg::OUT_W-1:0];
        res_status <= sat ? lrs_pkg::ST_SAT : lrs_pkg::ST_OK;
      end
    end
  end

endmodule

[hw/rtl/lrs_ctrl.sv]
// Controller: sequences one request through divide, multiply, divide-by-3
// and sum steps, and hands the result to the output stage. Depends on lrs_pkg.
module lrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lrs_pkg::dp_stat_t stat,
  input  logic              out_free,
  output lrs_pkg::dp_cmd_t  cmd
);

  lrs_pkg::state_t           state;
  lrs_pkg::state_t           state_next;
  logic [lrs_pkg::CNT_W-1:0] cnt;
  logic [lrs_pkg::CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrs_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      lrs_pkg::S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = lrs_pkg::S_CHECK;
        end
      end
      lrs_pkg::S_CHECK: begin
        priority if (stat.skip) begin
          state_next = lrs_pkg::S_IDLE;
        end else if (stat.prev_zero) begin
          cmd.zero_res = 1'b1;
          state_next   = lrs_pkg::S_EMIT;
        end else if (stat.too_big) begin
          cmd.clamp  = 1'b1;
          state_next = lrs_pkg::S_X;
        end else begin
          cnt_next   = lrs_pkg::DIV_LAST;
          state_next = lrs_pkg::S_DIV;
        end
      end
      lrs_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = lrs_pkg::S_X;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      lrs_pkg::S_X: begin
        cmd.form_x = 1'b1;
        state_next = lrs_pkg::S_SQ;
      end
      lrs_pkg::S_SQ: begin
        cmd.mul_sq = 1'b1;
        state_next = lrs_pkg::S_MLO;
      end
      lrs_pkg::S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = lrs_pkg::S_MHI;
      end
      lrs_pkg::S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = lrs_pkg::S_ACC;
      end
      lrs_pkg::S_ACC: begin
        cmd.acc    = 1'b1;
        cnt_next   = lrs_pkg::D3_LAST;
        state_next = lrs_pkg::S_DIV3;
      end
      lrs_pkg::S_DIV3: begin
        cmd.d3_step = 1'b1;
        if (cnt == '0) begin
          state_next = lrs_pkg::S_SUM;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      lrs_pkg::S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = lrs_pkg::S_EMIT;
      end
      lrs_pkg::S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = lrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lrs_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == lrs_pkg::S_CHECK))
    else $error("accepted request did not enter check");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == lrs_pkg::S_DIV && cnt == '0) |=> (state == lrs_pkg::S_X))
    else $error("divider did not hand over after last step");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result loaded into a full output stage");

  a_d3_bound: assert property (@(posedge clk) disable iff (rst)
    (state == lrs_pkg::S_DIV3) |-> (cnt <= lrs_pkg::D3_LAST))
    else $error("divide-by-3 step count out of range");

endmodule

[hw/rtl/log_return_stream_core.sv]
// Log return stream core: a request passes check, the 32-step radix-2 ratio
// divider, multiplies, the 12-step divide-by-3 and sum; a clamped ratio skips
// the divider, a zero previous price skips to the output, and a request giving
// no result ends at check. No new request is taken until the FSM is idle again.
// The output register frees the controller while a result waits.
// Synchronous reset clears the stored price, its flag, the FSM and result_valid.
module log_return_stream_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic [lrs_pkg::PRICE_W-1:0]        price,
  input  logic                               new_series,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [lrs_pkg::OUT_W-1:0]   log_return,
  output logic [1:0]                         status
);

  lrs_pkg::dp_cmd_t            cmd;
  lrs_pkg::dp_stat_t           stat;
  logic [lrs_pkg::OUT_W-1:0]   res;
  logic [1:0]                  res_status;
  logic                        out_free;

  assign out_free = ~result_valid | ~result_stall;

  lrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .out_free   (out_free),
    .cmd        (cmd)
  );

  lrs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .price      (price),
    .new_series (new_series),
    .res        (res),
    .res_status (res_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      log_return <= res;
      status     <= res_status;
    end
  end

endmodule

[sim/tb_log_return_stream_core.sv]
// Self-checking testbench for log_return_stream_core: directed and random price streams,
// a cubic log-return predictor and random idling on both the request and result channels.
// Depends on lrs_pkg and log_return_stream_core only.
module tb_log_return_stream_core;

  typedef struct packed {
    logic [lrs_pkg::PRICE_W-1:0] price;
    logic                        new_series;
  } price_req_t;

  typedef struct packed {
    logic signed [lrs_pkg::OUT_W-1:0] log_return;
    logic [1:0]                       status;
  } log_result_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             item_valid = 1'b0;
  logic                             item_stall;
  logic [lrs_pkg::PRICE_W-1:0]      price = '0;
  logic                             new_series = 1'b0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic signed [lrs_pkg::OUT_W-1:0] log_return;
  logic [1:0]                       status;

  price_req_t  price_queue[$];
  log_result_t expected_returns[$];
  price_req_t  next_req;
  log_result_t seen_return;

  logic [lrs_pkg::PRICE_W-1:0] last_price = '0;
  bit                          have_last = 1'b0;
  bit                          item_taken = 1'b0;
  int                          send_gap = 0;
  int                          send_quiet = 0;
  int                          stall_left = 0;
  int                          stall_quiet = 0;
  int                          error_count = 0;

  log_return_stream_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .price        (price),
    .new_series   (new_series),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .log_return   (log_return),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int idle_len(input int quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet > 0) return 0;
    if (r < 25) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // ratio = cur * 2^F / prev, x = ratio - 1, result x - x^2/2 + x^3/3 with each term truncated
  task automatic predict_log_return(input logic [lrs_pkg::PRICE_W-1:0] cur,
                                    input logic start);
    logic [lrs_pkg::PRICE_W-1:0] prev;
    bit                          had;
    logic [63:0]                 ratio, ax, s2, m3;
    logic [127:0]                prod;
    longint                      x, total;
    log_result_t                 res;
    prev = last_price;
    had = have_last;
    last_price = cur;
    have_last = 1'b1;
    if (start || !had) return;
    if (prev == '0) begin
      res.log_return = '0;
      res.status = lrs_pkg::ST_DIV0;
      expected_returns.push_back(res);
      return;
    end
    res.status = lrs_pkg::ST_OK;
    if ((64'(cur) / 64'(prev)) >= 64'd256) begin
      ratio = (64'd256 << lrs_pkg::FRAC_W) - 64'd1;
      res.status = lrs_pkg::ST_SAT;
    end else begin
      ratio = (64'(cur) << lrs_pkg::FRAC_W) / 64'(prev);
    end
    x = longint'(ratio) - (longint'(1) << lrs_pkg::FRAC_W);
    ax = (x < 0) ? 64'(-x) : 64'(x);
    s2 = (ax * ax) >> lrs_pkg::FRAC_W;
    prod = 128'(s2) * 128'(ax);
    m3 = 64'(prod >> lrs_pkg::FRAC_W);
    total = x - longint'(s2 >> 1);
    if (x < 0) total = total - longint'(m3 / 64'd3);
    else total = total + longint'(m3 / 64'd3);
    if (total > 64'sd2147483647) begin
      total = 64'sd2147483647;
      res.status = lrs_pkg::ST_SAT;
    end else if (total < -64'sd2147483648) begin
      total = -64'sd2147483648;
      res.status = lrs_pkg::ST_SAT;
    end
    res.log_return = lrs_pkg::OUT_W'(total);
    expected_returns.push_back(res);
  endtask

  task automatic queue_price(input logic [lrs_pkg::PRICE_W-1:0] p, input logic ns);
    price_req_t r;
    r.price = p;
    r.new_series = ns;
    price_queue.push_back(r);
  endtask

  // request side
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (send_quiet > 0) send_quiet <= send_quiet - 1;
      else if ($urandom_range(0, 99) < 3) send_quiet <= $urandom_range(10, 40);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        item_valid <= 1'b0;
      end else if (price_queue.size() != 0) begin
        next_req = price_queue.pop_front();
        price <= next_req.price;
        new_series <= next_req.new_series;
        item_valid <= 1'b1;
        send_gap <= idle_len(send_quiet);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= 1'b0;
      if (stall_quiet > 0) stall_quiet <= stall_quiet - 1;
      else if ($urandom_range(0, 99) < 3) stall_quiet <= $urandom_range(10, 60);
      stall_left <= idle_len(stall_quiet);
    end
  end

  always @(posedge clk) begin
    item_taken <= !rst && item_valid && !item_stall;
    if (!rst && result_valid && !result_stall) begin
      if (expected_returns.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h status %0d", log_return, status));
      end else begin
        seen_return = expected_returns.pop_front();
        if (log_return !== seen_return.log_return)
          report_mismatch($sformatf("log_return %h, expected %h",
                                    log_return, seen_return.log_return));
        if (status !== seen_return.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, seen_return.status));
      end
    end
    if (!rst && item_valid && !item_stall) predict_log_return(price, new_series);
  end

  initial begin
    int                          i, pick, sh;
    logic [lrs_pkg::PRICE_W-1:0] p, gen_last, delta;
    logic                        ns;

    // no stored price after reset, then equal, falling to zero, zero previous
    queue_price(32'h0001_0000, 1'b0);
    queue_price(32'h0001_0000, 1'b0);
    queue_price(32'h0000_0000, 1'b0);
    queue_price(32'h0001_0000, 1'b0);
    queue_price(32'hFFFF_FFFF, 1'b0);
    queue_price(32'hFFFF_FFFF, 1'b0);
    queue_price(32'h0000_0001, 1'b0);
    queue_price(32'h0000_0001, 1'b1);
    queue_price(32'h0000_0100, 1'b0);
    queue_price(32'h0000_0001, 1'b1);
    queue_price(32'h0000_00FF, 1'b0);
    queue_price(32'h0000_0000, 1'b1);
    queue_price(32'h0000_0000, 1'b0);
    queue_price(32'h0001_8000, 1'b1);
    queue_price(32'h0001_0000, 1'b0);
    queue_price(32'h0002_0000, 1'b0);
    queue_price(32'h0002_0001, 1'b0);
    queue_price(32'h0001_FFFF, 1'b0);
    queue_price(32'h8000_0000, 1'b0);
    queue_price(32'h7FFF_FFFF, 1'b1);
    queue_price(32'h8000_0000, 1'b0);
    queue_price(32'h5555_5555, 1'b0);
    queue_price(32'hAAAA_AAAA, 1'b0);

    gen_last = 32'hAAAA_AAAA;
    for (i = 0; i < 450; i++) begin
      pick = $urandom_range(0, 99);
      ns = ($urandom_range(0, 9) == 0);
      if (pick < 55) begin
        sh = $urandom_range(0, 24);
        delta = $urandom_range(0, 1 << sh);
        p = $urandom_range(0, 1) ? gen_last + delta : gen_last - delta;
      end else if (pick < 70) begin
        p = $urandom();
      end else if (pick < 80) begin
        if ($urandom_range(0, 1)) p = gen_last >> $urandom_range(1, 12);
        else p = gen_last * $urandom_range(2, 300);
      end else if (pick < 85) begin
        p = '0;
      end else if (pick < 90) begin
        p = '1;
      end else begin
        p = $urandom_range(0, 255);
      end
      queue_price(p, ns);
      gen_last = p;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (price_queue.size() != 0 || item_valid) @(posedge clk);
    while (expected_returns.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
